FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion helpers, disabled while the active-low reset is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every edge outside reset
`define ASSERT_CLK(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent
`define ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/cfs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfs_pkg
// Shared types and operation codes of the coordinate queue with search.
// ----------------------------------------------------------------------------
package cfs_pkg;

    typedef logic [1:0] kind_t;

    localparam kind_t KIND_PUSH   = 2'd0;
    localparam kind_t KIND_POP    = 2'd1;
    localparam kind_t KIND_SEARCH = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic tail_load;
        logic scan;
        logic load_out;
    } cfs_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic empty;
        logic last;
        logic hit;
        logic drained;
    } cfs_status_t;

endpackage

FILE: sv/cfs_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfs_datapath
// Ring memory, pointers, occupancy, search scan and result register.
// ----------------------------------------------------------------------------
module cfs_datapath #(
    parameter int QUEUE_DEPTH = 256,
    parameter int COORD_BITS  = 8
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  cfs_pkg::cfs_cmd_t                  cmd,
    output cfs_pkg::cfs_status_t               status,
    input  cfs_pkg::kind_t                     s_kind,
    input  logic [COORD_BITS-1:0]              s_coord_x,
    input  logic [COORD_BITS-1:0]              s_coord_y,
    output logic                               m_found,
    output logic [COORD_BITS-1:0]              m_head_x,
    output logic [COORD_BITS-1:0]              m_head_y,
    output logic [COORD_BITS-1:0]              m_tail_x,
    output logic [COORD_BITS-1:0]              m_tail_y,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]   m_occupancy,
    output logic                               m_is_empty,
    output logic                               m_overflow,
    output logic                               m_underflow
);
    import cfs_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int ENT_W = 2 * COORD_BITS;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
        return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
    endfunction

    logic [ENT_W-1:0] mem [QUEUE_DEPTH];
    logic [ENT_W-1:0] rd_data_reg;

    logic [PTR_W-1:0] wp_reg, wp_next;
    logic [PTR_W-1:0] rp_reg, rp_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [PTR_W-1:0] scan_ptr_reg, scan_ptr_next;
    logic [CNT_W-1:0] scan_left_reg, scan_left_next;
    logic             cmp_vld_reg, cmp_vld_next;
    logic [ENT_W-1:0] key_reg, key_next;
    logic [ENT_W-1:0] head_reg, head_next;
    logic [ENT_W-1:0] tail_reg, tail_next;
    logic             found_reg, found_next;
    logic             ovf_reg, ovf_next;
    logic             unf_reg, unf_next;

    logic             is_empty, is_full, do_push, do_pop, do_search;
    logic [ENT_W-1:0] in_entry;

    assign is_empty  = (count_reg == '0);
    assign is_full   = (count_reg == CNT_FULL);
    assign in_entry  = {s_coord_x, s_coord_y};
    assign do_push   = cmd.accept && (s_kind == KIND_PUSH) && !is_full;
    assign do_pop    = cmd.accept && (s_kind == KIND_POP) && !is_empty;
    assign do_search = cmd.accept && (s_kind == KIND_SEARCH);

    assign status.empty   = is_empty;
    assign status.last    = (count_reg == CNT_ONE);
    assign status.hit     = cmp_vld_reg && (rd_data_reg == key_reg);
    assign status.drained = (scan_left_reg == '0) && !cmp_vld_reg;

    always_comb begin
        wp_next        = wp_reg;
        rp_next        = rp_reg;
        count_next     = count_reg;
        scan_ptr_next  = scan_ptr_reg;
        scan_left_next = scan_left_reg;
        cmp_vld_next   = cmd.scan && (scan_left_reg != '0);
        key_next       = key_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        found_next     = found_reg;
        ovf_next       = ovf_reg;
        unf_next       = unf_reg;

        if (cmd.accept) begin
            found_next = 1'b0;
            ovf_next   = (s_kind == KIND_PUSH) && is_full;
            unf_next   = (s_kind == KIND_POP) && is_empty;
            key_next   = in_entry;
        end
        if (do_push) begin
            wp_next    = next_ptr(wp_reg);
            count_next = count_reg + CNT_W'(1);
            head_next  = in_entry;
            if (is_empty) begin
                tail_next = in_entry;
            end
        end
        if (do_pop) begin
            rp_next       = next_ptr(rp_reg);
            count_next    = count_reg - CNT_W'(1);
            scan_ptr_next = next_ptr(rp_reg);
        end
        if (do_search) begin
            scan_ptr_next  = rp_reg;
            scan_left_next = count_reg;
        end
        if (cmd.scan && (scan_left_reg != '0)) begin
            scan_ptr_next  = next_ptr(scan_ptr_reg);
            scan_left_next = scan_left_reg - CNT_W'(1);
        end
        if (cmd.scan && status.hit) begin
            found_next = 1'b1;
        end
        if (cmd.tail_load) begin
            tail_next = rd_data_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wp_reg] <= in_entry;
        end
        rd_data_reg <= mem[scan_ptr_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg      <= '0;
            rp_reg      <= '0;
            count_reg   <= '0;
            cmp_vld_reg <= 1'b0;
        end else begin
            wp_reg      <= wp_next;
            rp_reg      <= rp_next;
            count_reg   <= count_next;
            cmp_vld_reg <= cmp_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        scan_ptr_reg  <= scan_ptr_next;
        scan_left_reg <= scan_left_next;
        key_reg       <= key_next;
        head_reg      <= head_next;
        tail_reg      <= tail_next;
        found_reg     <= found_next;
        ovf_reg       <= ovf_next;
        unf_reg       <= unf_next;
    end

    // result register
    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_found     <= found_reg;
            m_head_x    <= is_empty ? '0 : head_reg[ENT_W-1:COORD_BITS];
            m_head_y    <= is_empty ? '0 : head_reg[COORD_BITS-1:0];
            m_tail_x    <= is_empty ? '0 : tail_reg[ENT_W-1:COORD_BITS];
            m_tail_y    <= is_empty ? '0 : tail_reg[COORD_BITS-1:0];
            m_occupancy <= count_reg;
            m_is_empty  <= is_empty;
            m_overflow  <= ovf_reg;
            m_underflow <= unf_reg;
        end
    end

endmodule

FILE: sv/cfs_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfs_controller
// Sequencer for push, pop, search and result transfer.
// ----------------------------------------------------------------------------
module cfs_controller (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  cfs_pkg::kind_t        s_kind,
    output logic                  m_valid,
    input  logic                  m_ready,
    output cfs_pkg::cfs_cmd_t     cmd,
    input  cfs_pkg::cfs_status_t  status
);
    import cfs_pkg::*;

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_TAIL_WAIT = 3'd1;
    localparam logic [2:0] S_TAIL_LOAD = 3'd2;
    localparam logic [2:0] S_SCAN      = 3'd3;
    localparam logic [2:0] S_DONE      = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       accept, out_free;

    assign s_ready  = (state_reg == S_IDLE);
    assign accept   = s_ready && s_valid;
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;

    assign cmd.accept    = accept;
    assign cmd.tail_load = (state_reg == S_TAIL_LOAD);
    assign cmd.scan      = (state_reg == S_SCAN);
    assign cmd.load_out  = (state_reg == S_DONE) && out_free;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    unique case (s_kind)
                        KIND_POP: begin
                            state_next = (status.empty || status.last) ? S_DONE : S_TAIL_WAIT;
                        end
                        KIND_SEARCH: begin
                            state_next = status.empty ? S_DONE : S_SCAN;
                        end
                        default: begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_TAIL_WAIT: state_next = S_TAIL_LOAD;
            S_TAIL_LOAD: state_next = S_DONE;
            S_SCAN: begin
                if (status.hit || status.drained) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        priority if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

FILE: sv/coordinate_fifo_with_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coordinate_fifo_with_search
// Bounded ring-buffer queue of (x,y) coordinates with push, pop and search.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  s_      | in        | s_valid / s_ready  | s_kind, s_coord_x, s_coord_y
//  m_      | out       | m_valid / m_ready  | m_found, head, tail, occupancy, flags
//
//  Push, no-op, dropped push, empty or last-entry pop, empty search: straight from idle to done.
//  Pop of two or more: tail wait, then tail load, the new oldest entry comes through the ring read port.
//  Search: scans from the oldest entry until a hit or the last entry, one compare a cycle.
//  In the datapath, reset clears pointers, count and the compare-valid flag only; entries are undefined until written.
//  A finished result waits in the output register; the next transfer is taken meanwhile.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module coordinate_fifo_with_search #(
    parameter int QUEUE_DEPTH = 256,
    parameter int COORD_BITS  = 8
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  cfs_pkg::kind_t                     s_kind,
    input  logic [COORD_BITS-1:0]              s_coord_x,
    input  logic [COORD_BITS-1:0]              s_coord_y,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_found,
    output logic [COORD_BITS-1:0]              m_head_x,
    output logic [COORD_BITS-1:0]              m_head_y,
    output logic [COORD_BITS-1:0]              m_tail_x,
    output logic [COORD_BITS-1:0]              m_tail_y,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]   m_occupancy,
    output logic                               m_is_empty,
    output logic                               m_overflow,
    output logic                               m_underflow
);
    import cfs_pkg::*;

    localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(QUEUE_DEPTH);

    cfs_cmd_t    cmd;
    cfs_status_t status;

    cfs_controller u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_kind  (s_kind),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .status  (status)
    );

    cfs_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .COORD_BITS  (COORD_BITS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .status      (status),
        .s_kind      (s_kind),
        .s_coord_x   (s_coord_x),
        .s_coord_y   (s_coord_y),
        .m_found     (m_found),
        .m_head_x    (m_head_x),
        .m_head_y    (m_head_y),
        .m_tail_x    (m_tail_x),
        .m_tail_y    (m_tail_y),
        .m_occupancy (m_occupancy),
        .m_is_empty  (m_is_empty),
        .m_overflow  (m_overflow),
        .m_underflow (m_underflow)
    );

    `ASSERT_NEXT(a_busy_after_transfer, aclk, aresetn, s_valid && s_ready, !s_ready, "ready after transfer")
    `ASSERT_CLK(a_occ_bound, aclk, aresetn, m_valid |-> (m_occupancy <= OCC_FULL), "occupancy beyond depth")
    `ASSERT_CLK(a_empty_flag, aclk, aresetn, m_valid |-> (m_is_empty == (m_occupancy == '0)), "empty flag mismatch")
    `ASSERT_CLK(a_ovf_full, aclk, aresetn, (m_valid && m_overflow) |-> (m_occupancy == OCC_FULL), "overflow when not full")
    `ASSERT_CLK(a_unf_empty, aclk, aresetn, (m_valid && m_underflow) |-> m_is_empty, "underflow when not empty")

endmodule

FILE: tb/sv/tb_coordinate_fifo_with_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_coordinate_fifo_with_search
// Self-checking bench for the coordinate queue with search. A queue model
// predicts head, tail, occupancy and flags for every input transfer, and
// each output transfer is checked against it. The run covers the corner
// cases, fills the queue to overflow, drains part of it, and adds
// random traffic with random gaps and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_coordinate_fifo_with_search;
    import cfs_pkg::*;

    localparam int DEPTH      = 256;
    localparam int CB         = 8;
    localparam int OCC_BITS   = $clog2(DEPTH + 1);
    localparam int HOLD_AT    = 1500;
    localparam int HOLD_LEN   = 500;
    localparam int IDLE_LIMIT = 5000;
    localparam int TAIL_WAIT  = 300;
    localparam kind_t KIND_NONE = 2'd3;

    typedef struct packed {
        kind_t         kind;
        logic [CB-1:0] x;
        logic [CB-1:0] y;
    } queue_op_t;

    typedef struct packed {
        logic                found;
        logic [CB-1:0]       head_x;
        logic [CB-1:0]       head_y;
        logic [CB-1:0]       tail_x;
        logic [CB-1:0]       tail_y;
        logic [OCC_BITS-1:0] occupancy;
        logic                is_empty;
        logic                overflow;
        logic                underflow;
    } queue_status_t;

    logic                aclk        = 1'b0;
    logic                aresetn     = 1'b0;
    logic                s_valid     = 1'b0;
    logic                s_ready;
    kind_t               s_kind      = KIND_PUSH;
    logic [CB-1:0]       s_coord_x   = '0;
    logic [CB-1:0]       s_coord_y   = '0;
    logic                m_valid;
    logic                m_ready     = 1'b0;
    logic                m_found;
    logic [CB-1:0]       m_head_x;
    logic [CB-1:0]       m_head_y;
    logic [CB-1:0]       m_tail_x;
    logic [CB-1:0]       m_tail_y;
    logic [OCC_BITS-1:0] m_occupancy;
    logic                m_is_empty;
    logic                m_overflow;
    logic                m_underflow;

    queue_op_t         pending_ops[$];
    queue_status_t     status_due[$];
    logic [2*CB-1:0]   held_coords[$];

    logic [CB-1:0]     store_x[DEPTH];
    logic [CB-1:0]     store_y[DEPTH];
    int                wr_slot = 0;
    int                rd_slot = 0;
    int                fill = 0;

    int                mismatch_count = 0;
    int                results_seen = 0;
    int                tx_wait = 0;
    int                tx_burst = 0;
    int                rx_wait = 0;
    int                rx_burst = 0;
    int                rx_cycles = 0;
    int                hold_left = 0;
    int                idle_cycles = 0;

    coordinate_fifo_with_search #(
        .QUEUE_DEPTH(DEPTH),
        .COORD_BITS (CB)
    ) dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_kind     (s_kind),
        .s_coord_x  (s_coord_x),
        .s_coord_y  (s_coord_y),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_found    (m_found),
        .m_head_x   (m_head_x),
        .m_head_y   (m_head_y),
        .m_tail_x   (m_tail_x),
        .m_tail_y   (m_tail_y),
        .m_occupancy(m_occupancy),
        .m_is_empty (m_is_empty),
        .m_overflow (m_overflow),
        .m_underflow(m_underflow)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [CB-1:0] rand_coord();
        if ($urandom_range(0, 99) < 30)
            return CB'($urandom_range(0, 3));
        return CB'($urandom_range(0, (1 << CB) - 1));
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= 100)
            $display("%0t result %0d %0s: got %0h, expected %0h",
                     $realtime, results_seen, what, got, want);
    endtask

    // queue model, updated once per input transfer
    task automatic predict_status(input kind_t kind, input logic [CB-1:0] cx,
                                  input logic [CB-1:0] cy);
        queue_status_t st;
        int p;
        int h;
        st = '0;
        case (kind)
            KIND_PUSH: begin
                if (fill == DEPTH) begin
                    st.overflow = 1'b1;
                end else begin
                    store_x[wr_slot] = cx;
                    store_y[wr_slot] = cy;
                    wr_slot = (wr_slot + 1) % DEPTH;
                    fill++;
                end
            end
            KIND_POP: begin
                if (fill == 0) begin
                    st.underflow = 1'b1;
                end else begin
                    rd_slot = (rd_slot + 1) % DEPTH;
                    fill--;
                end
            end
            KIND_SEARCH: begin
                p = rd_slot;
                for (int i = 0; i < fill && !st.found; i++) begin
                    if (store_x[p] == cx && store_y[p] == cy)
                        st.found = 1'b1;
                    p = (p + 1) % DEPTH;
                end
            end
            default: ;
        endcase
        if (fill != 0) begin
            h = (wr_slot + DEPTH - 1) % DEPTH;
            st.head_x = store_x[h];
            st.head_y = store_y[h];
            st.tail_x = store_x[rd_slot];
            st.tail_y = store_y[rd_slot];
        end
        st.occupancy = OCC_BITS'(fill);
        st.is_empty  = (fill == 0);
        status_due.push_back(st);
    endtask

    // stimulus list plus a shadow of the stored coordinates for shaping it
    task automatic add_op(input kind_t kind, input logic [CB-1:0] x,
                          input logic [CB-1:0] y);
        queue_op_t op;
        op.kind = kind;
        op.x    = x;
        op.y    = y;
        pending_ops.push_back(op);
        if (kind == KIND_PUSH && held_coords.size() < DEPTH)
            held_coords.push_back({x, y});
        else if (kind == KIND_POP && held_coords.size() > 0)
            void'(held_coords.pop_front());
    endtask

    task automatic add_search(input int hit_pct);
        logic [2*CB-1:0] v;
        if (held_coords.size() > 0 && $urandom_range(0, 99) < hit_pct) begin
            v = held_coords[$urandom_range(0, held_coords.size() - 1)];
            add_op(KIND_SEARCH, v[2*CB-1:CB], v[CB-1:0]);
        end else begin
            add_op(KIND_SEARCH, rand_coord(), rand_coord());
        end
    endtask

    task automatic add_random_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            add_op(KIND_PUSH, rand_coord(), rand_coord());
        else if (r < 70)
            add_op(KIND_POP, rand_coord(), rand_coord());
        else if (r < 95)
            add_search(60);
        else
            add_op(KIND_NONE, rand_coord(), rand_coord());
    endtask

    always @(posedge aclk) begin
        queue_op_t op;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                predict_status(s_kind, s_coord_x, s_coord_y);
            if (!s_valid || s_ready) begin
                if (tx_wait > 0) begin
                    tx_wait--;
                    s_valid <= 1'b0;
                end else if (pending_ops.size() != 0) begin
                    op = pending_ops.pop_front();
                    s_kind    <= op.kind;
                    s_coord_x <= op.x;
                    s_coord_y <= op.y;
                    s_valid   <= 1'b1;
                    if (tx_burst > 0) begin
                        tx_burst--;
                        tx_wait = 0;
                    end else begin
                        tx_wait = pick_gap();
                        if ($urandom_range(0, 39) == 0)
                            tx_burst = $urandom_range(16, 48);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: random stalls plus one long hold-off to back the queue up
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            rx_cycles++;
            if (rx_cycles == HOLD_AT)
                hold_left = HOLD_LEN;
            if (m_valid && m_ready) begin
                if (rx_burst > 0) begin
                    rx_burst--;
                    rx_wait = 0;
                end else begin
                    rx_wait = pick_gap();
                    if ($urandom_range(0, 39) == 0)
                        rx_burst = $urandom_range(16, 48);
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        queue_status_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (status_due.size() == 0) begin
                report_mismatch("transfer with nothing expected", 32'd0, 32'd0);
            end else begin
                want = status_due.pop_front();
                if (m_found !== want.found)
                    report_mismatch("found", 32'(m_found), 32'(want.found));
                if (m_head_x !== want.head_x)
                    report_mismatch("head_x", 32'(m_head_x), 32'(want.head_x));
                if (m_head_y !== want.head_y)
                    report_mismatch("head_y", 32'(m_head_y), 32'(want.head_y));
                if (m_tail_x !== want.tail_x)
                    report_mismatch("tail_x", 32'(m_tail_x), 32'(want.tail_x));
                if (m_tail_y !== want.tail_y)
                    report_mismatch("tail_y", 32'(m_tail_y), 32'(want.tail_y));
                if (m_occupancy !== want.occupancy)
                    report_mismatch("occupancy", 32'(m_occupancy), 32'(want.occupancy));
                if (m_is_empty !== want.is_empty)
                    report_mismatch("is_empty", 32'(m_is_empty), 32'(want.is_empty));
                if (m_overflow !== want.overflow)
                    report_mismatch("overflow", 32'(m_overflow), 32'(want.overflow));
                if (m_underflow !== want.underflow)
                    report_mismatch("underflow", 32'(m_underflow), 32'(want.underflow));
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles == IDLE_LIMIT) begin
                $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int r;
        logic [2*CB-1:0] v;

        // corner cases
        add_op(KIND_POP, '0, '0);
        add_op(KIND_SEARCH, '0, '0);
        add_op(KIND_NONE, '1, '1);
        add_op(KIND_PUSH, '0, '0);
        add_op(KIND_PUSH, '1, '1);
        add_op(KIND_PUSH, '0, '1);
        add_op(KIND_PUSH, '1, '0);
        add_op(KIND_SEARCH, '1, '1);
        add_op(KIND_SEARCH, '0, '0);
        add_op(KIND_SEARCH, '1, '0);
        add_op(KIND_SEARCH, '1, 8'hfe);
        add_op(KIND_SEARCH, 8'h55, 8'haa);
        add_op(KIND_NONE, 8'haa, 8'h55);
        add_op(KIND_POP, '0, '0);
        add_op(KIND_POP, '1, '1);
        add_op(KIND_PUSH, '1, '1);
        add_op(KIND_SEARCH, '1, '1);
        add_op(KIND_POP, '0, '0);
        add_op(KIND_POP, '0, '0);
        add_op(KIND_POP, '0, '0);
        add_op(KIND_POP, '0, '0);

        repeat (40)
            add_random_op();

        // fill to full, then dropped pushes and full-depth searches
        while (held_coords.size() < DEPTH) begin
            if ($urandom_range(0, 99) < 12)
                add_search(70);
            else
                add_op(KIND_PUSH, rand_coord(), rand_coord());
        end
        repeat (4) begin
            add_op(KIND_PUSH, rand_coord(), rand_coord());
            add_search(50);
        end
        v = held_coords[held_coords.size() - 1];
        add_op(KIND_SEARCH, v[2*CB-1:CB], v[CB-1:0]);
        v = held_coords[0];
        add_op(KIND_SEARCH, v[2*CB-1:CB], v[CB-1:0]);

        // partial drain, then pops and searches
        while (held_coords.size() > DEPTH - 32) begin
            r = $urandom_range(0, 99);
            if (r < 85)
                add_op(KIND_POP, rand_coord(), rand_coord());
            else if (r < 95)
                add_search(60);
            else if (r < 98)
                add_op(KIND_PUSH, rand_coord(), rand_coord());
            else
                add_op(KIND_NONE, rand_coord(), rand_coord());
        end
        repeat (3) begin
            add_op(KIND_POP, rand_coord(), rand_coord());
            add_search(50);
        end

        repeat (20)
            add_random_op();

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_ops.size() != 0 || s_valid || status_due.size() != 0)
            @(negedge aclk);
        repeat (TAIL_WAIT) @(negedge aclk);

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+sv
sv/cfs_pkg.sv
sv/cfs_datapath.sv
sv/cfs_controller.sv
sv/coordinate_fifo_with_search.sv
tb/sv/tb_coordinate_fifo_with_search.sv
